>>> hw/rtl/ldu_pkg.sv
// ----------------------------------------------------------------------------
// ldu_pkg
// Shared constants for the LDU matrix decomposer: port widths, fixed-point
// format and the fixed divider geometry.
// ----------------------------------------------------------------------------
package ldu_pkg;

  // port widths fixed by the item format
  localparam int DATA_W    = 32;   // a_value / entry_value
  localparam int INDEX_W   = 3;    // row_index / col_index
  localparam int CFG_W     = 4;    // matrix_size register
  localparam int SIZE_RST  = 8;    // matrix_size after reset

  // Q16.16 format
  localparam int FRAC_BITS = 16;

  // reciprocal divider: dividend 2^32 + |d|/2, one quotient bit per cycle
  localparam int DIV_W     = 2 * FRAC_BITS + 1;
  localparam int DIVCNT_W  = 6;

endpackage

>>> hw/rtl/ldu_matrix_decomposer_unit.sv
// ----------------------------------------------------------------------------
// ldu_matrix_decomposer_unit
// Loads an n x n Q16.16 matrix row-major, factors it in place as L*D*U
// without pivoting, then streams the packed factors row-major.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+--------------
//  config   | cfg_write, cfg_data                       | write enable
//  input    | in_valid, in_ready, a_value               | valid/ready
//  output   | out_valid, out_ready, row_index,          | valid/ready
//           | col_index, entry_value, last_entry,       |
//           | zero_pivot                                |
//
// Loading accepts one item per cycle. The item that completes the matrix
// starts factoring: per entry a read of A, then a read-L, read-U,
// multiply, subtract step per k below min(i,j) through one shared rounding
// multiplier and one matrix memory read port, a write-back off the diagonal
// and the bit-serial reciprocal divider per nonzero pivot. Output steps per
// entry through memory read, register and handshake, plus any out_ready stall.
// in_ready is low from factoring start until the last entry is taken.
// Reset is synchronous and clears control state; the memory is not cleared.
module ldu_matrix_decomposer_unit #(
  parameter int MAX_DIM     = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ldu_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ldu_pkg::DATA_W-1:0]   a_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ldu_pkg::INDEX_W-1:0]         row_index,
  output logic [ldu_pkg::INDEX_W-1:0]         col_index,
  output logic signed [ldu_pkg::DATA_W-1:0]   entry_value,
  output logic                                last_entry,
  output logic                                zero_pivot
);

  localparam int EW    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int IW    = $clog2(MAX_DIM);
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PW    = AW + NW + 1;
  localparam int FB    = ldu_pkg::FRAC_BITS;
  localparam int DW    = ldu_pkg::DIV_W;

  localparam logic signed [EW-1:0]   VMAX_E = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0]   VMIN_E = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [2*EW-1:0] PMAX   = (2*EW)'(VMAX_E);
  localparam logic signed [2*EW-1:0] PMIN   = (2*EW)'(VMIN_E);
  localparam logic signed [2*EW-1:0] HALF   = (2*EW)'(1) <<< (FB - 1);

  typedef enum logic [3:0] {
    S_LOAD, S_RD_A, S_LD_ACC, S_RD_L, S_RD_U, S_MUL2, S_SUB,
    S_FIN, S_WR, S_DIV, S_DIVEND, S_OUT_RD, S_OUT_SHOW, S_OUT_WAIT
  } state_t;

  state_t state;

  logic [ldu_pkg::CFG_W-1:0] matrix_size;
  logic [CW-1:0]             element_count;
  logic                      pivot_flag;
  logic [NW-1:0]             n_cur;
  logic [IW-1:0]             n_m1;
  logic [IW-1:0]             i, j, k;
  logic signed [EW-1:0]      acc;
  logic signed [EW-1:0]      mres;
  logic signed [EW-1:0]      dvec  [MAX_DIM];
  logic signed [EW-1:0]      recip [MAX_DIM];

  // matrix memory
  logic signed [EW-1:0]      mem [DEPTH];
  logic signed [EW-1:0]      rdata;
  logic [AW-1:0]             raddr, waddr;
  logic signed [EW-1:0]      wdata;
  logic                      we;

  // reciprocal divider
  logic [DW-1:0]                 dnum, dquo;
  logic [EW:0]                   drem;
  logic [EW-1:0]                 dden;
  logic                          dneg;
  logic [ldu_pkg::DIVCNT_W-1:0]  dcnt;

  // ---------------------------------------------------------------------------
  // Size clamp and address helpers
  // ---------------------------------------------------------------------------
  logic [NW-1:0] n_cfg;
  logic [CW-1:0] total_cfg;
  always_comb begin
    if (matrix_size == '0) begin
      n_cfg = NW'(1);
    end else if (ldu_pkg::CFG_W'(matrix_size) > ldu_pkg::CFG_W'(MAX_DIM)) begin
      n_cfg = NW'(MAX_DIM);
    end else begin
      n_cfg = NW'(matrix_size);
    end
    total_cfg = CW'(n_cfg) * CW'(n_cfg);
  end

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                            input logic [NW-1:0] n);
    logic [PW-1:0] t;
    t = PW'(r) * PW'(n) + PW'(c);
    return t[AW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Shared rounding multiplier: (a*b + 2^15) >>> 16, saturated
  // ---------------------------------------------------------------------------
  logic signed [EW-1:0]   mul_a, mul_b, mul_y;
  logic signed [2*EW-1:0] mul_p, mul_s;
  logic [IW-1:0]          kend;

  assign kend = (j < i) ? j : i;

  always_comb begin
    unique case (state)
      S_RD_U: begin
        mul_a = dvec[k];
        mul_b = rdata;
      end
      S_MUL2: begin
        mul_a = mres;
        mul_b = rdata;
      end
      default: begin
        mul_a = acc;
        mul_b = recip[kend];
      end
    endcase
    mul_p = (2*EW)'(mul_a) * (2*EW)'(mul_b) + HALF;
    mul_s = mul_p >>> FB;
    if (mul_s > PMAX) begin
      mul_y = VMAX_E;
    end else if (mul_s < PMIN) begin
      mul_y = VMIN_E;
    end else begin
      mul_y = EW'(mul_s);
    end
  end

  // saturating accumulator subtract
  logic signed [EW:0]   diff;
  logic signed [EW-1:0] diff_sat;
  always_comb begin
    diff = {acc[EW-1], acc} - {mres[EW-1], mres};
    if (diff[EW] != diff[EW-1]) begin
      diff_sat = diff[EW] ? VMIN_E : VMAX_E;
    end else begin
      diff_sat = EW'(diff);
    end
  end

  // input saturation to the value width
  logic signed [63:0]   a_ext;
  logic signed [EW-1:0] a_sat;
  always_comb begin
    a_ext = 64'(a_value);
    if (a_ext > 64'(VMAX_E)) begin
      a_sat = VMAX_E;
    end else if (a_ext < 64'(VMIN_E)) begin
      a_sat = VMIN_E;
    end else begin
      a_sat = EW'(a_ext);
    end
  end

  // divider step and final sign/saturate
  logic [EW:0]          rem_sh;
  logic                 qbit;
  logic signed [DW+1:0] qs;
  logic signed [EW-1:0] q_sat;
  always_comb begin
    rem_sh = {drem[EW-1:0], dnum[DW-1]};
    qbit   = (rem_sh >= {1'b0, dden});
    qs     = dneg ? -$signed({2'b00, dquo}) : $signed({2'b00, dquo});
    if (qs > (DW+2)'(VMAX_E)) begin
      q_sat = VMAX_E;
    end else if (qs < (DW+2)'(VMIN_E)) begin
      q_sat = VMIN_E;
    end else begin
      q_sat = EW'(qs);
    end
  end

  // absolute value of the pivot
  logic [EW-1:0] acc_abs;
  assign acc_abs = acc[EW-1] ? EW'(-acc) : EW'(acc);

  // ---------------------------------------------------------------------------
  // Advance to the next entry of the sweep
  // ---------------------------------------------------------------------------
  logic    last_j, last_i;
  state_t  adv_state;
  logic [IW-1:0] adv_i, adv_j;
  always_comb begin
    last_j = (j == n_m1);
    last_i = (i == n_m1);
    adv_i  = i;
    adv_j  = j + IW'(1);
    adv_state = S_RD_A;
    if (last_j) begin
      adv_j = '0;
      if (last_i) begin
        adv_i     = '0;
        adv_state = S_OUT_RD;
      end else begin
        adv_i = i + IW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Memory ports
  // ---------------------------------------------------------------------------
  logic [CW:0] count_inc;
  assign count_inc = (CW+1)'(element_count) + (CW+1)'(1);
  assign in_ready  = (state == S_LOAD);

  always_comb begin
    unique case (state)
      S_RD_L:  raddr = addr_of(i, k, n_cur);
      S_RD_U:  raddr = addr_of(k, j, n_cur);
      default: raddr = addr_of(i, j, n_cur);
    endcase
    we    = 1'b0;
    waddr = addr_of(i, j, n_cur);
    wdata = mres;
    if (state == S_LOAD) begin
      we    = in_valid && (CW'(element_count) < CW'(DEPTH));
      waddr = element_count[AW-1:0];
      wdata = a_sat;
    end else if (state == S_FIN && i == j) begin
      we    = 1'b1;
      wdata = acc;
    end else if (state == S_WR) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      matrix_size   <= ldu_pkg::CFG_W'(ldu_pkg::SIZE_RST);
      element_count <= '0;
      pivot_flag    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        matrix_size <= cfg_data;
      end
      unique case (state)
        // take matrix elements; start factoring on the last one
        S_LOAD: begin
          if (in_valid) begin
            if (count_inc >= (CW+1)'(total_cfg)) begin
              element_count <= '0;
              pivot_flag    <= 1'b0;
              n_cur         <= n_cfg;
              n_m1          <= IW'(n_cfg - NW'(1));
              i             <= '0;
              j             <= '0;
              state         <= S_RD_A;
            end else begin
              element_count <= CW'(count_inc);
            end
          end
        end
        S_RD_A: begin
          state <= S_LD_ACC;
        end
        S_LD_ACC: begin
          acc   <= rdata;
          k     <= '0;
          state <= (kend == '0) ? S_FIN : S_RD_L;
        end
        S_RD_L: begin
          state <= S_RD_U;
        end
        // D(k)*L(i,k)
        S_RD_U: begin
          mres  <= mul_y;
          state <= S_MUL2;
        end
        // times U(k,j)
        S_MUL2: begin
          mres  <= mul_y;
          state <= S_SUB;
        end
        S_SUB: begin
          acc <= diff_sat;
          k   <= k + IW'(1);
          state <= ((k + IW'(1)) == kend) ? S_FIN : S_RD_L;
        end
        // pivot: store D and start its reciprocal, or flag a zero pivot and take max; else scale by reciprocal
        S_FIN: begin
          if (i == j) begin
            dvec[i] <= acc;
            if (acc == '0) begin
              pivot_flag <= 1'b1;
              recip[i]   <= VMAX_E;
              i          <= adv_i;
              j          <= adv_j;
              state      <= adv_state;
            end else begin
              dnum  <= {1'b1, {(DW-1){1'b0}}} + DW'(acc_abs >> 1);
              dden  <= acc_abs;
              dneg  <= acc[EW-1];
              drem  <= '0;
              dquo  <= '0;
              dcnt  <= ldu_pkg::DIVCNT_W'(DW - 1);
              state <= S_DIV;
            end
          end else begin
            mres  <= mul_y;
            state <= S_WR;
          end
        end
        S_WR: begin
          i     <= adv_i;
          j     <= adv_j;
          state <= adv_state;
        end
        // one quotient bit per cycle
        S_DIV: begin
          drem <= qbit ? (rem_sh - {1'b0, dden}) : rem_sh;
          dquo <= {dquo[DW-2:0], qbit};
          dnum <= {dnum[DW-2:0], 1'b0};
          if (dcnt == '0) begin
            state <= S_DIVEND;
          end else begin
            dcnt <= dcnt - ldu_pkg::DIVCNT_W'(1);
          end
        end
        S_DIVEND: begin
          recip[i] <= q_sat;
          i        <= adv_i;
          j        <= adv_j;
          state    <= adv_state;
        end
        // stream packed factors
        S_OUT_RD: begin
          state <= S_OUT_SHOW;
        end
        S_OUT_SHOW: begin
          row_index   <= ldu_pkg::INDEX_W'(i);
          col_index   <= ldu_pkg::INDEX_W'(j);
          entry_value <= ldu_pkg::DATA_W'(rdata);
          last_entry  <= last_i && last_j;
          zero_pivot  <= pivot_flag;
          out_valid   <= 1'b1;
          state       <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_i && last_j) begin
              state <= S_LOAD;
            end else begin
              i     <= adv_i;
              j     <= adv_j;
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

>>> test/ldu_matrix_decomposer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ldu_matrix_decomposer_unit_test
// Loads matrices of several sizes through the valid/ready input, predicts the
// packed L/D/U factors in Q16.16 and checks every output entry in order.
// ----------------------------------------------------------------------------
module ldu_matrix_decomposer_unit_test;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int LIMIT = 400000;

  typedef struct {
    logic [ldu_pkg::INDEX_W-1:0]       row;
    logic [ldu_pkg::INDEX_W-1:0]       col;
    logic signed [ldu_pkg::DATA_W-1:0] value;
    logic                              last;
    logic                              zp;
  } factor_entry_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [ldu_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [ldu_pkg::DATA_W-1:0] a_value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [ldu_pkg::INDEX_W-1:0] row_index, col_index;
  logic signed [ldu_pkg::DATA_W-1:0] entry_value;
  logic last_entry, zero_pivot;

  ldu_matrix_decomposer_unit u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .a_value(a_value),
    .out_valid(out_valid), .out_ready(out_ready), .row_index(row_index),
    .col_index(col_index), .entry_value(entry_value), .last_entry(last_entry),
    .zero_pivot(zero_pivot)
  );

  always #2 clk = ~clk;

  // predictor state
  longint mat [64];
  longint recip [8];
  int load_count = 0;
  logic [ldu_pkg::CFG_W-1:0] size_reg = ldu_pkg::CFG_W'(ldu_pkg::SIZE_RST);
  logic pivot_seen;

  logic [ldu_pkg::DATA_W-1:0] a_feed [$];
  factor_entry_t expected_entries [$];

  int mismatches = 0;
  int cycles = 0;
  bit in_taken = 0, out_taken = 0;
  bit gaps_on = 1;
  bit hold_req = 0;
  int hold_cnt = 0, send_wait = 0, take_wait = 0;

  function automatic longint sat32(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  // round half up, floor shift
  function automatic longint q_mul(longint a, longint b);
    return sat32((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint q_recip(longint d);
    longint ad, q;
    if (d == 0) return VMAX;
    ad = (d < 0) ? -d : d;
    q = ((64'sd1 <<< 32) + ad / 2) / ad;
    if (d < 0) q = -q;
    return sat32(q);
  endfunction

  function automatic longint eliminate(longint acc, int n, int i, int j, int kend);
    for (int k = 0; k < kend; k++)
      acc = sat32(acc - q_mul(q_mul(mat[k*n+k], mat[i*n+k]), mat[k*n+j]));
    return acc;
  endfunction

  // factor in place and queue the packed entries
  function automatic void decompose(int n);
    longint d;
    factor_entry_t e;
    pivot_seen = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < i; j++)
        mat[i*n+j] = q_mul(eliminate(mat[i*n+j], n, i, j, j), recip[j]);
      d = eliminate(mat[i*n+i], n, i, i, i);
      mat[i*n+i] = d;
      if (d == 0) pivot_seen = 1;
      recip[i] = q_recip(d);
      for (int j = i + 1; j < n; j++)
        mat[i*n+j] = q_mul(eliminate(mat[i*n+j], n, i, j, i), recip[i]);
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        e.row = ldu_pkg::INDEX_W'(i);
        e.col = ldu_pkg::INDEX_W'(j);
        e.value = mat[i*n+j][31:0];
        e.last = (i == n - 1) && (j == n - 1);
        e.zp = pivot_seen;
        expected_entries.push_back(e);
      end
  endfunction

  function automatic void load_element(logic signed [ldu_pkg::DATA_W-1:0] v);
    int n;
    n = (size_reg < 1) ? 1 : (size_reg > 8) ? 8 : size_reg;
    if (load_count < 64) mat[load_count] = v;
    load_count++;
    if (load_count >= n * n) begin
      load_count = 0;
      decompose(n);
    end
  endfunction

  // half small well-scaled values, the rest full-range and edge values
  function automatic logic [ldu_pkg::DATA_W-1:0] draw_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed($urandom_range(0, 524288)) - 262144;
    if (sel < 7) return $urandom;
    if (sel == 7) return '0;
    if (sel == 8) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
  endfunction

  // sample handshakes and check results
  always @(posedge clk) begin
    cycles++;
    in_taken = 0;
    out_taken = 0;
    if (!rst && cfg_write) size_reg = cfg_data;
    if (!rst && in_valid && in_ready) begin
      in_taken = 1;
      load_element(a_value);
    end
    if (!rst && out_valid && out_ready) begin
      out_taken = 1;
      if (expected_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected entry r%0d c%0d value %h", row_index, col_index, entry_value);
      end else begin
        factor_entry_t e;
        e = expected_entries.pop_front();
        if (e.row !== row_index || e.col !== col_index || e.value !== entry_value ||
            e.last !== last_entry || e.zp !== zero_pivot) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"entry mismatch: exp r%0d c%0d %h last %b zp %b, ",
                      "got r%0d c%0d %h last %b zp %b"},
                     e.row, e.col, e.value, e.last, e.zp,
                     row_index, col_index, entry_value, last_entry, zero_pivot);
        end
      end
    end
  end

  // drive input items from the pending queue
  always @(negedge clk) begin
    logic nv;
    nv = in_valid;
    if (in_valid && in_taken) begin
      nv = 0;
      send_wait = gaps_on ? $urandom_range(0, 9) : 0;
    end
    if (!nv && !rst) begin
      if (send_wait > 0) send_wait--;
      else if (a_feed.size() > 0) begin
        a_value <= a_feed.pop_front();
        nv = 1;
      end
    end
    in_valid <= nv;
  end

  // accept results, with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 3000;
      hold_req = 0;
    end
    if (out_taken) take_wait = gaps_on ? $urandom_range(0, 9) : 0;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 0;
    end else if (take_wait > 0) begin
      take_wait--;
      out_ready <= 0;
    end else begin
      out_ready <= !rst;
    end
  end

  task automatic wait_idle();
    wait (a_feed.size() == 0 && !in_valid && expected_entries.size() == 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_size(logic [ldu_pkg::CFG_W-1:0] v);
    wait_idle();
    cfg_write <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 0;
    @(negedge clk);
  endtask

  task automatic queue_random(int count);
    for (int k = 0; k < count; k++) a_feed.push_back(draw_value());
  endtask

  // stimulus phases
  initial begin
    repeat (12) @(negedge clk);
    rst <= 0;

    // one-by-one: zero pivot, extremes, unity
    write_size(ldu_pkg::CFG_W'(1));
    a_feed.push_back(32'h00000000);
    a_feed.push_back(32'h7fffffff);
    a_feed.push_back(32'h80000000);
    a_feed.push_back(32'hffff0000);
    // two-by-two: zero leading pivot, then a regular matrix
    write_size(ldu_pkg::CFG_W'(2));
    a_feed.push_back(32'h00000000);
    a_feed.push_back(32'h00010000);
    a_feed.push_back(32'h00010000);
    a_feed.push_back(32'h00010000);
    a_feed.push_back(32'h00040000);
    a_feed.push_back(32'h00020000);
    a_feed.push_back(32'h7fffffff);
    a_feed.push_back(32'h80000000);
    // size zero acts as one
    write_size(ldu_pkg::CFG_W'(0));
    a_feed.push_back(32'h00030000);
    a_feed.push_back(32'hfffe8000);

    gaps_on = 0;
    write_size(ldu_pkg::CFG_W'(3));
    queue_random(27);

    // above the maximum acts as the maximum; receiver held off while more
    // items keep coming, so the block fills and stalls its input
    gaps_on = 1;
    write_size(ldu_pkg::CFG_W'(15));
    hold_req = 1;
    queue_random(72);

    // change size part way through a load
    write_size(ldu_pkg::CFG_W'(5));
    queue_random(10);
    write_size(ldu_pkg::CFG_W'(2));
    queue_random(2);

    // finish on a 4x4 run
    write_size(ldu_pkg::CFG_W'(4));
    queue_random(16);
    wait_idle();

    if (mismatches == 0) $display("ldu_matrix_decomposer_unit: match");
    else $display("ldu_matrix_decomposer_unit: mismatch");
    $finish;
  end

  // run limit
  initial begin
    wait (cycles >= LIMIT);
    $display("ldu_matrix_decomposer_unit: mismatch");
    $finish;
  end

endmodule
